### rtl/pnc_pkg.sv
// Package for the perfect number checker: widths, and the command and
// status groups that pass between the controller and the datapath.
// No dependencies.
`default_nettype none

package pnc_pkg;

    localparam int VALUE_WIDTH = 31;
    localparam int SUM_WIDTH   = 34;
    // The exact proper divisor sum stays below eight times the number, so the
    // running sum also holds it when the number is made wider.
    localparam int RUN_WIDTH   = (VALUE_WIDTH + 3 > 35) ? VALUE_WIDTH + 3 : 35;
    localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic div_start;
        logic add_i;
        logic add_j;
        logic next_cand;
        logic finish;
    } pnc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
        logic cand_ok;
    } pnc_sts_t;

endpackage

`default_nettype wire

### rtl/pnc_divider.sv
// Restoring divider, one quotient bit per cycle, for the checker datapath.
// Depends on pnc_pkg.
`default_nettype none

module pnc_divider
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [pnc_pkg::VALUE_WIDTH-1:0] dividend,
    input  wire logic [pnc_pkg::VALUE_WIDTH-1:0] divisor,
    output logic      [pnc_pkg::VALUE_WIDTH-1:0] quotient,
    output logic      [pnc_pkg::VALUE_WIDTH-1:0] remainder,
    output logic                                 done
);

    logic                            run_reg;
    logic                            run_next;
    logic                            done_reg;
    logic                            done_next;
    logic [pnc_pkg::CNT_WIDTH-1:0]   cnt_reg;
    logic [pnc_pkg::CNT_WIDTH-1:0]   cnt_next;
    logic [pnc_pkg::VALUE_WIDTH-1:0] rem_reg;
    logic [pnc_pkg::VALUE_WIDTH-1:0] rem_next;
    logic [pnc_pkg::VALUE_WIDTH-1:0] quo_reg;
    logic [pnc_pkg::VALUE_WIDTH-1:0] quo_next;
    logic [pnc_pkg::VALUE_WIDTH:0]   trial;
    logic [pnc_pkg::VALUE_WIDTH:0]   diff;
    logic                            last_step;

    // The quotient register first holds the dividend; its top bit shifts
    // into the partial remainder while quotient bits shift in below.
    assign trial     = {rem_reg, quo_reg[pnc_pkg::VALUE_WIDTH-1]};
    assign diff      = trial - {1'b0, divisor};
    assign last_step = (cnt_reg == pnc_pkg::CNT_WIDTH'(pnc_pkg::VALUE_WIDTH - 1));

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            rem_next = '0;
            quo_next = dividend;
        end
        else if (run_reg)
        begin
            if (!diff[pnc_pkg::VALUE_WIDTH])
            begin
                rem_next = diff[pnc_pkg::VALUE_WIDTH-1:0];
                quo_next = {quo_reg[pnc_pkg::VALUE_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[pnc_pkg::VALUE_WIDTH-1:0];
                quo_next = {quo_reg[pnc_pkg::VALUE_WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (last_step)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

`default_nettype wire

### rtl/pnc_datapath.sv
// Datapath of the perfect number checker: number, candidate, running sum,
// result registers and the shared divider. Depends on pnc_pkg, pnc_divider.
`default_nettype none

module pnc_datapath
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire pnc_pkg::pnc_cmd_t               cmd,
    output pnc_pkg::pnc_sts_t                    sts,
    input  wire logic [pnc_pkg::VALUE_WIDTH-1:0] number_value,
    output logic                                 is_perfect,
    output logic      [pnc_pkg::SUM_WIDTH-1:0]   divisor_sum
);

    logic [pnc_pkg::VALUE_WIDTH-1:0] n_reg;
    logic [pnc_pkg::VALUE_WIDTH-1:0] cand_reg;
    logic [pnc_pkg::RUN_WIDTH-1:0]   sum_reg;
    logic [pnc_pkg::RUN_WIDTH-1:0]   sum_next;
    logic                            perfect_reg;
    logic [pnc_pkg::SUM_WIDTH-1:0]   out_sum_reg;
    logic [pnc_pkg::VALUE_WIDTH-1:0] quotient;
    logic [pnc_pkg::VALUE_WIDTH-1:0] remainder;
    logic                            div_done;
    logic                            divides;
    logic [pnc_pkg::VALUE_WIDTH-1:0] addend;
    logic                            add_en;
    logic [pnc_pkg::RUN_WIDTH:0]     add_full;

    pnc_divider u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (n_reg),
        .divisor   (cand_reg),
        .quotient  (quotient),
        .remainder (remainder),
        .done      (div_done)
    );

    assign divides = (remainder == '0);

    // The walk goes on while the candidate does not exceed the quotient,
    // which is the same as candidate squared not exceeding the number.
    assign sts.div_done = div_done;
    assign sts.cand_ok  = (quotient >= cand_reg);

    // The small divisor is added first, unless it equals the number; its cofactor follows
    // in the next cycle unless it repeats the small one or equals the number itself.
    always_comb
    begin
        addend = cand_reg;
        add_en = 1'b0;
        if (cmd.add_i)
        begin
            addend = cand_reg;
            add_en = divides && (cand_reg != n_reg);
        end
        else if (cmd.add_j)
        begin
            addend = quotient;
            add_en = divides && (quotient != cand_reg) && (quotient != n_reg);
        end
    end

    assign add_full = {1'b0, sum_reg} + (pnc_pkg::RUN_WIDTH + 1)'(addend);

    always_comb
    begin
        sum_next = sum_reg;
        if (cmd.load)
        begin
            sum_next = '0;
        end
        else if (add_en)
        begin
            if (add_full[pnc_pkg::RUN_WIDTH])
            begin
                sum_next = '1;
            end
            else
            begin
                sum_next = add_full[pnc_pkg::RUN_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg     <= '0;
            n_reg       <= '0;
            cand_reg    <= '0;
            perfect_reg <= 1'b0;
            out_sum_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
            if (cmd.load)
            begin
                n_reg    <= number_value;
                cand_reg <= pnc_pkg::VALUE_WIDTH'(1);
            end
            else if (cmd.next_cand)
            begin
                cand_reg <= cand_reg + 1'b1;
            end
            if (cmd.finish)
            begin
                perfect_reg <= (n_reg != '0)
                               && (sum_reg == pnc_pkg::RUN_WIDTH'(n_reg));
                if (|sum_reg[pnc_pkg::RUN_WIDTH-1:pnc_pkg::SUM_WIDTH])
                begin
                    out_sum_reg <= '1;
                end
                else
                begin
                    out_sum_reg <= sum_reg[pnc_pkg::SUM_WIDTH-1:0];
                end
            end
        end
    end

    assign is_perfect  = perfect_reg;
    assign divisor_sum = out_sum_reg;

endmodule

`default_nettype wire

### rtl/pnc_ctrl.sv
// Controller of the perfect number checker: steps the candidate walk and
// raises the result strobe. Depends on pnc_pkg.
`default_nettype none

module pnc_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire pnc_pkg::pnc_sts_t sts,
    output pnc_pkg::pnc_cmd_t      cmd,
    output logic                   busy,
    output logic                   done
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LAUNCH = 3'd1;
    localparam logic [2:0] S_WAIT   = 3'd2;
    localparam logic [2:0] S_TEST   = 3'd3;
    localparam logic [2:0] S_ADDJ   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       done_reg;
    logic       done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_LAUNCH;
                end
            end
            S_LAUNCH:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_WAIT;
            end
            S_WAIT:
            begin
                if (sts.div_done)
                begin
                    state_next = S_TEST;
                end
            end
            S_TEST:
            begin
                if (sts.cand_ok)
                begin
                    cmd.add_i  = 1'b1;
                    state_next = S_ADDJ;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_ADDJ:
            begin
                cmd.add_j     = 1'b1;
                cmd.next_cand = 1'b1;
                state_next    = S_LAUNCH;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

`default_nettype wire

### rtl/perfect_number_check.sv
// Perfect number checker: sums the proper divisors of n, pairing each divisor up to sqrt(n) with n/d.
// Each candidate waits on the shared divider, which yields one quotient bit per cycle.
// Throughput: one number at a time; start is taken once busy is low, which is already
// the done cycle. Done is a one-cycle strobe; is_perfect and divisor_sum hold until the
// next number finishes.
// Asynchronous active-low reset returns the block to idle with no result pending.
`default_nettype none

module perfect_number_check
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [pnc_pkg::VALUE_WIDTH-1:0] number_value,
    output logic                                 busy,
    output logic                                 done,
    output logic                                 is_perfect,
    output logic      [pnc_pkg::SUM_WIDTH-1:0]   divisor_sum
);

    pnc_pkg::pnc_cmd_t cmd;
    pnc_pkg::pnc_sts_t sts;

    pnc_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    pnc_datapath u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .number_value (number_value),
        .is_perfect   (is_perfect),
        .divisor_sum  (divisor_sum)
    );

endmodule

`default_nettype wire
